// File: rtl/ubx_frame_builder_top_assert.svh
// Assertion macros shared by the UBX frame builder checkers.
// Needs a clock, and a reset except in UBX_ASSERT_NEXT_ANY, named at each use; reports through $error.
`ifndef UBX_FRAME_BUILDER_TOP_ASSERT_SVH
`define UBX_FRAME_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UBX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define UBX_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ubx_fb_pkg.sv
// Shared types and constants for the UBX frame builder.
// No dependencies; imported by the top level, the tracker and the testbench.
`timescale 1ns / 1ps

package ubx_fb_pkg;

  // Input opcodes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_t;

  // Frame sync bytes
  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  // Position of each word in the emit sequence
  localparam logic [2:0] IDX_SYNC1 = 3'd0;
  localparam logic [2:0] IDX_SYNC2 = 3'd1;
  localparam logic [2:0] IDX_CLASS = 3'd2;
  localparam logic [2:0] IDX_ID    = 3'd3;
  localparam logic [2:0] IDX_LENLO = 3'd4;
  localparam logic [2:0] IDX_DATA  = 3'd5;  // length high on start, data on payload
  localparam logic [2:0] IDX_CKA   = 3'd6;
  localparam logic [2:0] IDX_CKB   = 3'd7;

  // One emit job: everything needed to produce the words of one item
  typedef struct packed {
    logic       start;
    logic       close;
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] len_lo;
    logic [7:0] data;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
  } job_t;

endpackage

// File: rtl/ubx_frame_builder_top.sv
// UBX frame builder: an accepted word is held in the job register and its words pass
// through the output register. Payload words run at one per cycle unless out_stall
// holds them; a start word holds the input for its 6 words (8 with zero length), a
// frame-closing payload word for 3. The single output word per cycle sets the rate,
// stalls aside; the job register frees as its last word moves to the output register.
// Synchronous reset clears all control state. Depends on ubx_fb_pkg, ubx_fb_track.
`timescale 1ns / 1ps

module ubx_frame_builder_top import ubx_fb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  msg_class,
  input  logic [7:0]  msg_id,
  input  logic [15:0] payload_len,
  input  logic [7:0]  payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        frame_done
);

  logic       take;
  logic       load;
  job_t       job_in;

  job_t       job;
  logic       job_valid;
  logic [2:0] job_idx;

  logic       out_ready;
  logic       emit;
  logic [2:0] last_idx;
  logic       job_fin;
  logic [7:0] emit_byte;

  assign take = in_valid && !in_stall;

  ubx_fb_track u_track (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .opcode       (opcode),
    .msg_class    (msg_class),
    .msg_id       (msg_id),
    .payload_len  (payload_len),
    .payload_byte (payload_byte),
    .load         (load),
    .job          (job_in)
  );

  // Emit handshake with the output register
  assign out_ready = !out_valid || !out_stall;
  assign emit      = job_valid && out_ready;
  assign last_idx  = job.close ? IDX_CKB : IDX_DATA;
  assign job_fin   = emit && (job_idx == last_idx);
  assign in_stall  = job_valid && !job_fin;

  // Word select for the current position
  always_comb begin
    unique case (job_idx)
      IDX_SYNC1: emit_byte = SYNC_ONE;
      IDX_SYNC2: emit_byte = SYNC_TWO;
      IDX_CLASS: emit_byte = job.cls;
      IDX_ID:    emit_byte = job.id;
      IDX_LENLO: emit_byte = job.len_lo;
      IDX_DATA:  emit_byte = job.data;
      IDX_CKA:   emit_byte = job.ck_a;
      IDX_CKB:   emit_byte = job.ck_b;
      default:   emit_byte = job.data;
    endcase
  end

  // Job register and sequence position
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_idx   <= IDX_SYNC1;
    end else if (load) begin
      job_valid <= 1'b1;
      job_idx   <= job_in.start ? IDX_SYNC1 : IDX_DATA;
    end else if (job_fin) begin
      job_valid <= 1'b0;
    end else if (emit) begin
      job_idx <= job_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= emit_byte;
      last_of_run <= (job_idx == last_idx);
      frame_done  <= (job_idx == IDX_CKB);
    end
  end

endmodule

// File: rtl/ubx_fb_track.sv
// Frame tracker: open/closed state, byte count and Fletcher sums.
// Depends on ubx_fb_pkg; builds the emit job for each accepted word.
`timescale 1ns / 1ps

module ubx_fb_track import ubx_fb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        opcode,
  input  logic [7:0]  msg_class,
  input  logic [7:0]  msg_id,
  input  logic [15:0] payload_len,
  input  logic [7:0]  payload_byte,
  output logic        load,
  output job_t        job
);

  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] bytes_left;
  logic        frame_open;

  logic [7:0]  sum_a_next;
  logic [7:0]  sum_b_next;
  logic [15:0] bytes_left_next;
  logic        frame_open_next;

  logic        is_start;
  logic [7:0]  len_lo;
  logic [7:0]  len_hi;
  logic [7:0]  seed_a;
  logic [7:0]  seed_b;
  logic [7:0]  pay_a;
  logic [7:0]  pay_b;
  logic        pay_last;

  assign is_start = (opcode == OP_START);
  assign len_lo   = payload_len[7:0];
  assign len_hi   = payload_len[15:8];

  // Header seed in closed form: four folds of class, id, len lo, len hi
  assign seed_a = msg_class + msg_id + len_lo + len_hi;
  assign seed_b = {msg_class[5:0], 2'b00} + {msg_id[6:0], 1'b0} + msg_id
                  + {len_lo[6:0], 1'b0} + len_hi;

  // One fold for a payload word
  assign pay_a    = sum_a + payload_byte;
  assign pay_b    = sum_b + pay_a;
  assign pay_last = (bytes_left == 16'd1);

  assign load = take && (is_start || frame_open);

  // Job contents for the emitter
  always_comb begin
    job.start  = is_start;
    job.cls    = msg_class;
    job.id     = msg_id;
    job.len_lo = len_lo;
    if (is_start) begin
      job.close = (payload_len == 16'd0);
      job.data  = len_hi;
      job.ck_a  = seed_a;
      job.ck_b  = seed_b;
    end else begin
      job.close = pay_last;
      job.data  = payload_byte;
      job.ck_a  = pay_a;
      job.ck_b  = pay_b;
    end
  end

  // Frame state update
  always_comb begin
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    if (load) begin
      if (is_start) begin
        sum_a_next      = seed_a;
        sum_b_next      = seed_b;
        bytes_left_next = payload_len;
        frame_open_next = (payload_len != 16'd0);
      end else begin
        sum_a_next      = pay_a;
        sum_b_next      = pay_b;
        bytes_left_next = 16'(bytes_left - 16'd1);
        frame_open_next = !pay_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a      <= 8'd0;
      sum_b      <= 8'd0;
      bytes_left <= 16'd0;
      frame_open <= 1'b0;
    end else begin
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

endmodule

// File: rtl/ubx_fb_checker.sv
// Port-level checks for the UBX frame builder, bound to the top level.
// Depends on ubx_frame_builder_top_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "ubx_frame_builder_top_assert.svh"

module ubx_fb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        last_of_run,
  input logic        frame_done
);

  // A held result word keeps its contents
  `UBX_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_of_run) && $stable(frame_done), "output word changed while stalled")

  // The closing checksum word always ends its run
  `UBX_ASSERT_IMPL(a_done_last, clk, rst, out_valid && frame_done, last_of_run, "frame end without end of run")

  // Input is only held back while words are pending, so output follows
  `UBX_ASSERT_NEXT(a_stall_work, clk, rst, in_stall, out_valid, "input stalled with no output pending")

  // Reset leaves no word on the output
  `UBX_ASSERT_NEXT_ANY(a_rst_empty, clk, rst, !out_valid, "output valid after reset")

endmodule

bind ubx_frame_builder_top ubx_fb_checker u_chk (.*);

// File: bench/tb_ubx_frame_builder_top.sv
// Self-checking testbench for ubx_frame_builder_top: drives start and payload
// words, predicts every framed output byte with its own Fletcher-8 model, and
// checks each output word in order. Depends on ubx_fb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_ubx_frame_builder_top import ubx_fb_pkg::*; ();

  // One input word with the idle cycles that precede it
  typedef struct {
    opcode_t     op;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  data;
    int          gap;
  } src_word_t;

  // One output word of the frame
  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       done;
  } tx_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [7:0]  msg_class = 8'h00;
  logic [7:0]  msg_id = 8'h00;
  logic [15:0] payload_len = 16'h0000;
  logic [7:0]  payload_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        frame_done;

  src_word_t src_words_q[$];
  tx_word_t  frame_bytes_q[$];

  // Predictor state
  logic [7:0]  fl_a = 8'h00;
  logic [7:0]  fl_b = 8'h00;
  logic [15:0] len_left = 16'h0000;
  logic        in_frame = 1'b0;

  // Bookkeeping
  int n_errors = 0;
  int n_accepted = 0;
  int n_queued = 0;
  int n_checked = 0;
  int n_starts = 0;
  int n_abandoned = 0;
  int n_dropped = 0;
  int src_mode = 1;
  int rx_mode = 1;
  logic hold_req = 1'b0;

  src_word_t cur_word;
  int        src_gap = 0;
  int        rx_gap = 0;
  tx_word_t  want_w;

  ubx_frame_builder_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .msg_class    (msg_class),
    .msg_id       (msg_id),
    .payload_len  (payload_len),
    .payload_byte (payload_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle cycles per word: 0 = none, 1 = uniform 0..16, 2 = mostly back to back
  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  // ---------------- prediction ----------------

  task automatic fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endtask

  task automatic push_tx(input logic [7:0] b, input logic last, input logic done);
    tx_word_t w;
    w.b = b;
    w.last = last;
    w.done = done;
    frame_bytes_q.push_back(w);
  endtask

  task automatic emit_checksum();
    push_tx(fl_a, 1'b0, 1'b0);
    push_tx(fl_b, 1'b1, 1'b1);
    in_frame = 1'b0;
    len_left = 16'h0000;
  endtask

  task automatic build_frame_bytes(input src_word_t w);
    if (w.op == OP_START) begin
      n_starts++;
      if (in_frame) n_abandoned++;
      fl_a = 8'h00;
      fl_b = 8'h00;
      fletcher_add(w.cls);
      fletcher_add(w.id);
      fletcher_add(w.len[7:0]);
      fletcher_add(w.len[15:8]);
      push_tx(SYNC_ONE, 1'b0, 1'b0);
      push_tx(SYNC_TWO, 1'b0, 1'b0);
      push_tx(w.cls, 1'b0, 1'b0);
      push_tx(w.id, 1'b0, 1'b0);
      push_tx(w.len[7:0], 1'b0, 1'b0);
      if (w.len == 16'h0000) begin
        push_tx(w.len[15:8], 1'b0, 1'b0);
        emit_checksum();
      end else begin
        push_tx(w.len[15:8], 1'b1, 1'b0);
        len_left = w.len;
        in_frame = 1'b1;
      end
    end else if (!in_frame) begin
      n_dropped++;
    end else begin
      fletcher_add(w.data);
      len_left = len_left - 16'd1;
      if (len_left == 16'h0000) begin
        push_tx(w.data, 1'b0, 1'b0);
        emit_checksum();
      end else begin
        push_tx(w.data, 1'b1, 1'b0);
      end
    end
  endtask

  // ---------------- stimulus building ----------------

  task automatic queue_word(input src_word_t w);
    if (n_queued % 50 == 0) src_mode = $urandom_range(0, 2);
    w.gap = draw_gap(src_mode);
    src_words_q.push_back(w);
    n_queued++;
  endtask

  // Fields not used by the opcode are random
  task automatic queue_start(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len);
    src_word_t w;
    w.op = OP_START;
    w.cls = cls;
    w.id = id;
    w.len = len;
    w.data = 8'($urandom_range(0, 255));
    queue_word(w);
  endtask

  task automatic queue_data(input logic [7:0] d);
    src_word_t w;
    w.op = OP_PAYLOAD;
    w.cls = 8'($urandom_range(0, 255));
    w.id = 8'($urandom_range(0, 255));
    w.len = 16'($urandom_range(0, 65535));
    w.data = d;
    queue_word(w);
  endtask

  // Mostly short frames, a few empty ones, rarely a long one
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 12));
    if (r < 97) return 16'($urandom_range(13, 64));
    return 16'($urandom_range(200, 280));
  endfunction

  task automatic build_stimulus();
    int n_gen;
    int r;
    int sent;
    logic [15:0] len;
    logic gen_open;
    n_gen = 0;
    gen_open = 1'b0;

    // Directed: stray payload, empty frames with extreme headers, a one-byte frame,
    // a stray after close, and two frames abandoned by a new start
    queue_data(8'hFF);
    queue_start(8'h00, 8'h00, 16'h0000);
    queue_start(8'hFF, 8'hFF, 16'h0000);
    queue_start(8'h06, 8'h01, 16'h0001);
    queue_data(8'h00);
    queue_data(8'hAA);
    queue_start(8'hFF, 8'h00, 16'hFFFF);
    queue_data(8'hFF);
    queue_data(8'h00);
    queue_start(8'h0A, 8'hFF, 16'h0100);
    queue_data(8'h80);
    queue_data(8'h7F);
    queue_start(8'h01, 8'h07, 16'h0002);
    queue_data(8'hFF);
    queue_data(8'hFF);
    queue_start(8'h05, 8'h01, 16'h0003);
    queue_data(8'h01);
    queue_data(8'h02);
    queue_data(8'h03);

    // Random: well-formed frames, some cut short, some stray payload noise
    while (n_gen < 500) begin
      r = $urandom_range(0, 99);
      if (r < 8 && !gen_open) begin
        repeat ($urandom_range(1, 3)) queue_data(8'($urandom_range(0, 255)));
      end else begin
        len = pick_len();
        queue_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
        n_gen++;
        if (r < 20 && len > 16'd1) begin
          sent = $urandom_range(0, len - 1);
          gen_open = 1'b1;
        end else begin
          sent = len;
          gen_open = 1'b0;
        end
        for (int i = 0; i < sent; i++) begin
          queue_data(8'($urandom_range(0, 255)));
          n_gen++;
        end
      end
    end
  endtask

  // ---------------- driver ----------------

  // Predict on acceptance, then offer the next word after its idle cycles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        build_frame_bytes(cur_word);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (src_words_q.size() != 0) begin
          cur_word = src_words_q.pop_front();
          opcode <= cur_word.op;
          msg_class <= cur_word.cls;
          msg_id <= cur_word.id;
          payload_len <= cur_word.len;
          payload_byte <= cur_word.data;
          in_valid <= 1'b1;
          src_gap = (src_words_q.size() != 0) ? src_words_q[0].gap : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  // Check each accepted output word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_bytes_q.size() == 0) begin
          $display("%0t: unexpected output word: got byte %02h last %0d done %0d",
                   $time, out_byte, last_of_run, frame_done);
          n_errors++;
        end else begin
          want_w = frame_bytes_q.pop_front();
          if (out_byte !== want_w.b || last_of_run !== want_w.last ||
              frame_done !== want_w.done) begin
            $display("%0t: output word differs: expected byte %02h last %0d done %0d, got byte %02h last %0d done %0d",
                     $time, want_w.b, want_w.last, want_w.done,
                     out_byte, last_of_run, frame_done);
            n_errors++;
          end
        end
        n_checked++;
        if (n_checked % 64 == 0) rx_mode = $urandom_range(0, 2);
        rx_gap = draw_gap(rx_mode);
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      out_stall <= hold_req || (rx_gap != 0);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (n_accepted >= 150);
    @(posedge clk);
    hold_req <= 1'b1;
    repeat (300) @(posedge clk);
    hold_req <= 1'b0;
  end

  // ---------------- run control ----------------

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted != n_queued || frame_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d input words: %0d frame starts, %0d abandoned, %0d strays dropped",
             n_accepted, n_starts, n_abandoned, n_dropped);
    $display("Checked %0d output words, %0d errors", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("ubx_frame_builder_top: match");
    end else begin
      $display("ubx_frame_builder_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d words still expected", frame_bytes_q.size());
    $display("ubx_frame_builder_top: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ubx_fb_pkg.sv
rtl/ubx_fb_track.sv
rtl/ubx_frame_builder_top.sv
rtl/ubx_fb_checker.sv
bench/tb_ubx_frame_builder_top.sv
